[design/heartbeat_detector_bpm_top_assert.svh]
// assertion macros for the heartbeat detector top level
`ifndef HEARTBEAT_DETECTOR_BPM_TOP_ASSERT_SVH
`define HEARTBEAT_DETECTOR_BPM_TOP_ASSERT_SVH

// same-cycle implication, checked on every edge outside reset
`define HBD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heartbeat detector check failed");

// next-cycle implication, checked on every edge outside reset
`define HBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heartbeat detector check failed");

`endif

[design/hbd_pkg.sv]
package hbd_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BEAT_TIMEOUT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_FLOOR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVALS = 3'd5;

    // register widths
    localparam int PERIOD_W = 8;
    localparam int TMO_W    = 12;
    localparam int FLOOR_W  = 15;
    localparam int DECAY_W  = 16;
    localparam int MINIV_W  = 4;

    // register reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 8'd20;
    localparam logic [TMO_W-1:0]    TMO_RST    = 12'd2000;
    localparam logic [TMO_W-1:0]    MAXIV_RST  = 12'd3000;
    localparam logic [FLOOR_W-1:0]  FLOOR_RST  = 15'd200;
    localparam logic [DECAY_W-1:0]  DECAY_RST  = 16'd64881;
    localparam logic [MINIV_W-1:0]  MINIV_RST  = 4'd5;

    // level reset values
    localparam int UPPER_RST = 1000;
    localparam int LOWER_RST = 800;

    // time and rate
    localparam int ELAPSED_W = 13;
    localparam int IV_W      = 12;
    localparam int IV_MAX    = 4095;
    localparam int RATE_W    = 16;
    localparam int RATE_NUM  = 60000;
    localparam logic [RATE_W-1:0] RATE_MAX = 16'hFFFF;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DEC_U,
        ST_DEC_L,
        ST_DEC_W,
        ST_STORE,
        ST_RATE,
        ST_DIV,
        ST_FINISH
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic eval;
        logic dec_u;
        logic dec_l;
        logic dec_w;
        logic store;
        logic rate;
        logic fin;
    } hbd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic beat_phase;
        logic beat_ends;
        logic iv_keep;
        logic need_div;
        logic div_done;
    } hbd_status_t;

endpackage

[design/hbd_ctrl.sv]
module hbd_ctrl
    import hbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  hbd_status_t status,
    output hbd_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // state and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (!status.beat_phase)
                    state_next = ST_DEC_U;
                else if (status.beat_ends && status.iv_keep)
                    state_next = ST_STORE;
                else
                    state_next = ST_FINISH;
            end
            ST_DEC_U:
            begin
                cmd.dec_u  = 1'b1;
                state_next = ST_DEC_L;
            end
            ST_DEC_L:
            begin
                cmd.dec_l  = 1'b1;
                state_next = ST_DEC_W;
            end
            ST_DEC_W:
            begin
                cmd.dec_w  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = ST_RATE;
            end
            ST_RATE:
            begin
                cmd.rate   = 1'b1;
                state_next = status.need_div ? ST_DIV : ST_FINISH;
            end
            ST_DIV:
            begin
                if (status.div_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result beat handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.fin)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

endmodule

[design/hbd_div.sv]
module hbd_div
    import hbd_pkg::*;
#(
    parameter int NUM_W = 20,
    parameter int DEN_W = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  rem_next;
    logic [DEN_W-1:0]  den_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;

    // one quotient bit per cycle, restoring
    assign trial    = {rem_reg, quo_reg[NUM_W-1]};
    assign diff     = trial - {1'b0, den_reg};
    assign fits     = trial >= {1'b0, den_reg};
    assign rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

    assign done = done_reg;
    assign quot = quo_reg;

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == STEP_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

endmodule

[design/hbd_dp.sv]
module hbd_dp
    import hbd_pkg::*;
#(
    parameter int INTERVAL_SLOTS = 10,
    parameter int SAMPLE_WIDTH   = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  hbd_cmd_t                       cmd,
    output hbd_status_t                    status,
    output logic [RATE_W-1:0]              beats_per_minute,
    output logic                           beat_ended,
    output logic                           in_beat,
    output logic                           timed_out
);

    localparam int LVL_W  = ((SAMPLE_WIDTH > FLOOR_W) ? SAMPLE_WIDTH : FLOOR_W) + 1;
    localparam int MAG_W  = LVL_W - 1;
    localparam int PROD_W = MAG_W + DECAY_W;
    localparam int CNT_W  = $clog2(INTERVAL_SLOTS + 1);
    localparam int POS_W  = $clog2(INTERVAL_SLOTS);
    localparam int TOT_W  = $clog2(INTERVAL_SLOTS * IV_MAX + 1);
    localparam int NUM_W  = $clog2(INTERVAL_SLOTS * RATE_NUM + 1);
    localparam int MIN_W  = (CNT_W > MINIV_W) ? CNT_W : MINIV_W;
    localparam int NPR_W  = CNT_W + 16;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    // configuration registers
    logic [PERIOD_W-1:0] period_reg;
    logic [TMO_W-1:0]    tmo_reg;
    logic [TMO_W-1:0]    maxiv_reg;
    logic [FLOOR_W-1:0]  floor_reg;
    logic [DECAY_W-1:0]  decay_reg;
    logic [MINIV_W-1:0]  miniv_reg;

    // detector state
    logic                    phase_reg;
    logic signed [LVL_W-1:0] upper_reg;
    logic signed [LVL_W-1:0] lower_reg;
    logic signed [LVL_W-1:0] peak_reg;
    logic [POS_W-1:0]        pos_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [TOT_W-1:0]        total_reg;
    logic [ELAPSED_W-1:0]    elapsed_reg;
    logic [RATE_W-1:0]       rate_reg;
    logic                    ended_reg;

    // payload holding registers
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic [IV_W-1:0]                iv_reg;
    logic [IV_W-1:0]                ring_rd_reg;
    logic [PROD_W-1:0]              prod_reg;
    logic [IV_W-1:0]                ring_mem [INTERVAL_SLOTS];

    // result registers
    logic [RATE_W-1:0] bpm_out_reg;
    logic              ended_out_reg;
    logic              beat_out_reg;
    logic              tout_out_reg;

    logic signed [LVL_W-1:0] s_ext;
    logic signed [LVL_W-1:0] floor_lvl;
    logic signed [LVL_W-1:0] pk_new;
    logic [MAG_W+1:0]        pk3;
    logic [MAG_W-1:0]        mul_in;
    logic signed [LVL_W-1:0] decayed;
    logic [ELAPSED_W:0]      el_sum;
    logic [ELAPSED_W-1:0]    el_sat;
    logic                    full;
    logic [IV_W-1:0]         old_iv;
    logic [TOT_W-1:0]        total_next;
    logic [CNT_W-1:0]        count_next;
    logic [POS_W-1:0]        pos_next;
    logic                    above_min;
    logic                    div_start;
    logic [NPR_W-1:0]        num_full;
    logic                    div_done;
    logic [NUM_W-1:0]        div_quot;
    logic                    tout;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RST;
            tmo_reg    <= TMO_RST;
            maxiv_reg  <= MAXIV_RST;
            floor_reg  <= FLOOR_RST;
            decay_reg  <= DECAY_RST;
            miniv_reg  <= MINIV_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SAMPLE_PERIOD: period_reg <= cfg_data[PERIOD_W-1:0];
                REG_BEAT_TIMEOUT:  tmo_reg    <= cfg_data[TMO_W-1:0];
                REG_MAX_INTERVAL:  maxiv_reg  <= cfg_data[TMO_W-1:0];
                REG_THRESH_FLOOR:  floor_reg  <= cfg_data[FLOOR_W-1:0];
                REG_DECAY:         decay_reg  <= cfg_data[DECAY_W-1:0];
                REG_MIN_INTERVALS: miniv_reg  <= cfg_data[MINIV_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // sample and level arithmetic, levels never go negative
    assign s_ext     = {{(LVL_W - SAMPLE_WIDTH){sample_reg[SAMPLE_WIDTH-1]}}, sample_reg};
    assign floor_lvl = signed'(LVL_W'(floor_reg));
    assign pk_new    = (s_ext > peak_reg) ? s_ext : peak_reg;
    assign pk3       = (MAG_W + 2)'(pk_new[MAG_W-1:0]) + {1'b0, pk_new[MAG_W-1:0], 1'b0};
    assign mul_in    = cmd.dec_u ? upper_reg[MAG_W-1:0] : lower_reg[MAG_W-1:0];
    assign decayed   = signed'({1'b0, prod_reg[PROD_W-1:DECAY_W]});

    // elapsed time, saturating
    assign el_sum = (ELAPSED_W + 1)'(elapsed_reg) + (ELAPSED_W + 1)'(period_reg);
    assign el_sat = el_sum[ELAPSED_W] ? ELAPSED_MAX : el_sum[ELAPSED_W-1:0];

    // ring update
    assign full       = (count_reg == CNT_W'(INTERVAL_SLOTS));
    assign old_iv     = full ? ring_rd_reg : '0;
    assign total_next = total_reg - TOT_W'(old_iv) + TOT_W'(iv_reg);
    assign count_next = full ? count_reg : CNT_W'(count_reg + 1'b1);
    assign pos_next   = (pos_reg == POS_W'(INTERVAL_SLOTS - 1)) ? '0 : POS_W'(pos_reg + 1'b1);

    // rate setup
    assign above_min = MIN_W'(count_reg) > MIN_W'(miniv_reg);
    assign div_start = cmd.rate && status.need_div;
    assign num_full  = NPR_W'(count_reg) * NPR_W'(RATE_NUM);

    assign tout = elapsed_reg > ELAPSED_W'(tmo_reg);

    // status to controller
    assign status.beat_phase = phase_reg;
    assign status.beat_ends  = s_ext <= lower_reg;
    assign status.iv_keep    = elapsed_reg <= ELAPSED_W'(maxiv_reg);
    assign status.need_div   = above_min && (total_reg != '0);
    assign status.div_done   = div_done;

    hbd_div #(
        .NUM_W (NUM_W),
        .DEN_W (TOT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_full[NUM_W-1:0]),
        .den   (total_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // detector state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= 1'b0;
            upper_reg   <= LVL_W'(UPPER_RST);
            lower_reg   <= LVL_W'(LOWER_RST);
            peak_reg    <= '0;
            pos_reg     <= '0;
            count_reg   <= '0;
            total_reg   <= '0;
            elapsed_reg <= '0;
            rate_reg    <= '0;
            ended_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                elapsed_reg <= el_sat;
                ended_reg   <= 1'b0;
            end
            if (cmd.eval)
            begin
                if (!phase_reg)
                begin
                    if (s_ext >= upper_reg)
                    begin
                        phase_reg <= 1'b1;
                        peak_reg  <= s_ext;
                    end
                end
                else
                begin
                    peak_reg <= pk_new;
                    if (s_ext <= lower_reg)
                    begin
                        ended_reg   <= 1'b1;
                        elapsed_reg <= '0;
                        upper_reg   <= signed'({1'b0, pk3[MAG_W+1:2]});
                        lower_reg   <= signed'({2'b00, pk_new[MAG_W-1:1]});
                        phase_reg   <= 1'b0;
                    end
                end
            end
            if (cmd.dec_l)
                upper_reg <= (upper_reg > floor_lvl) ? decayed : floor_lvl;
            if (cmd.dec_w)
                lower_reg <= (lower_reg > floor_lvl) ? decayed : floor_lvl;
            if (cmd.store)
            begin
                total_reg <= total_next;
                count_reg <= count_next;
                pos_reg   <= pos_next;
            end
            if (cmd.rate)
            begin
                if (!above_min)
                    rate_reg <= '0;
                else if (total_reg == '0)
                    rate_reg <= RATE_MAX;
            end
            if (div_done)
                rate_reg <= (div_quot > NUM_W'(RATE_MAX)) ? RATE_MAX : div_quot[RATE_W-1:0];
            if (cmd.fin && tout)
            begin
                count_reg   <= '0;
                total_reg   <= '0;
                rate_reg    <= '0;
                elapsed_reg <= '0;
                phase_reg   <= 1'b0;
            end
        end
    end

    // sample, interval and multiplier registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
            sample_reg <= sample;
        if (cmd.eval)
            iv_reg <= elapsed_reg[IV_W-1:0];
        if (cmd.dec_u || cmd.dec_l)
            prod_reg <= PROD_W'(mul_in) * PROD_W'(decay_reg);
    end

    // interval ring memory
    always_ff @(posedge clk)
    begin
        if (cmd.store)
            ring_mem[pos_reg] <= iv_reg;
        if (cmd.eval)
            ring_rd_reg <= ring_mem[pos_reg];
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            bpm_out_reg   <= tout ? '0 : rate_reg;
            ended_out_reg <= ended_reg;
            beat_out_reg  <= tout ? 1'b0 : phase_reg;
            tout_out_reg  <= tout;
        end
    end

    assign beats_per_minute = bpm_out_reg;
    assign beat_ended       = ended_out_reg;
    assign in_beat          = beat_out_reg;
    assign timed_out        = tout_out_reg;

endmodule

[design/heartbeat_detector_bpm_top.sv]
// steps per sample: evaluate, then finish in a beat with no stored interval; while waiting,
// decay the levels (two passes of the shared level multiplier); when an interval is stored,
// store and rate, plus the bit-serial rate divider when the rate is divided, the longest path.
// throughput: a new sample is taken only after the last result goes to a free result side.
// reset: asynchronous, active low; configuration registers return to their defaults, phase
// waiting, levels 1000 and 800, history and rate zero. The interval ring itself is not cleared.
`include "heartbeat_detector_bpm_top_assert.svh"

module heartbeat_detector_bpm_top
    import hbd_pkg::*;
#(
    parameter int INTERVAL_SLOTS = 10,
    parameter int SAMPLE_WIDTH   = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [RATE_W-1:0]              beats_per_minute,
    output logic                           beat_ended,
    output logic                           in_beat,
    output logic                           timed_out
);

    hbd_cmd_t    cmd;
    hbd_status_t status;

    // sequencing
    hbd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // detector arithmetic and history
    hbd_dp #(
        .INTERVAL_SLOTS (INTERVAL_SLOTS),
        .SAMPLE_WIDTH   (SAMPLE_WIDTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .sample           (sample),
        .cmd              (cmd),
        .status           (status),
        .beats_per_minute (beats_per_minute),
        .beat_ended       (beat_ended),
        .in_beat          (in_beat),
        .timed_out        (timed_out)
    );

    // one sample in flight at a time
    `HBD_ASSERT_NEXT(a_single_item, in_valid && in_ready, !in_ready)
    // the sequencer issues at most one step per cycle
    `HBD_ASSERT_IMPL(a_cmd_onehot, 1'b1, $onehot0(cmd))
    // a timeout beat reports no rate and the waiting phase
    `HBD_ASSERT_IMPL(a_tout_clear, out_valid && timed_out, beats_per_minute == '0 && !in_beat)
    // a beat that just ended leaves the detector waiting
    `HBD_ASSERT_IMPL(a_end_waits, out_valid && beat_ended, !in_beat)

endmodule
